// ----- src/apt_pkg.sv -----
// Shared types and constants for the affine point transform.
// No dependencies.
`timescale 1ns / 1ps

package apt_pkg;

	localparam int CW = 32;          // coordinate and coefficient width
	localparam int REG_IDX_W = 3;    // config register index width
	localparam int NUM_REGS = 6;

	localparam logic [1:0] REQ_FULL    = 2'd0;
	localparam logic [1:0] REQ_LINEAR  = 2'd1;
	localparam logic [1:0] REQ_INVERSE = 2'd2;
	localparam logic [1:0] REQ_UNUSED  = 2'd3;   // answered as the full transform

	localparam logic [REG_IDX_W-1:0] REG_SCALE_X  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SHEAR_Y  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SHEAR_X  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SCALE_Y  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_X = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;

	typedef struct packed {
		logic [1:0]           req_type;
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
	} in_item_t;

	typedef struct packed {
		logic signed [CW-1:0] result_x;
		logic signed [CW-1:0] result_y;
		logic                 overflow;
		logic                 singular;
	} out_item_t;

	// operation flags that travel with each beat
	typedef struct packed {
		logic inv;
		logic full;
	} mode_t;

endpackage

// ----- src/apt_mac.sv -----
// Product and sum stages: four coordinate products, two determinant products,
// then the two weighted sums and the determinant. Uses apt_pkg.
`timescale 1ns / 1ps

module apt_mac #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               en,
	input  apt_pkg::mode_t                     mode_s1,
	input  logic signed [apt_pkg::CW:0]        ax_s1,
	input  logic signed [apt_pkg::CW:0]        by_s1,
	input  logic signed [apt_pkg::CW-1:0]      coef [apt_pkg::NUM_REGS],
	output apt_pkg::mode_t                     mode_s3,
	output logic signed [2*apt_pkg::CW+2:0]    ex_s3,
	output logic signed [2*apt_pkg::CW+2:0]    ey_s3,
	output logic signed [2*apt_pkg::CW:0]      det_s3
);

	localparam int W  = apt_pkg::CW;
	localparam int PW = 2*W+1;
	localparam int SW = 2*W+3;
	localparam int DPW = 2*W;

	logic signed [W-1:0] sx, shy, shx, sy, tx, ty;
	assign sx  = coef[apt_pkg::REG_SCALE_X];
	assign shy = coef[apt_pkg::REG_SHEAR_Y];
	assign shx = coef[apt_pkg::REG_SHEAR_X];
	assign sy  = coef[apt_pkg::REG_SCALE_Y];
	assign tx  = coef[apt_pkg::REG_OFFSET_X];
	assign ty  = coef[apt_pkg::REG_OFFSET_Y];

	apt_pkg::mode_t         mode_s2;
	logic signed [PW-1:0]   m0_s2, m1_s2, m2_s2, m3_s2;
	logic signed [DPW-1:0]  d0_s2, d1_s2;
	logic signed [W-1:0]    c0, c2;

	// inverse swaps the diagonal (adjugate)
	assign c0 = mode_s1.inv ? sy : sx;
	assign c2 = mode_s1.inv ? sx : sy;

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			m0_s2   <= PW'(ax_s1) * PW'(c0);
			m1_s2   <= PW'(by_s1) * PW'(shx);
			m2_s2   <= PW'(by_s1) * PW'(c2);
			m3_s2   <= PW'(ax_s1) * PW'(shy);
			d0_s2   <= DPW'(sx) * DPW'(sy);
			d1_s2   <= DPW'(shy) * DPW'(shx);
		end
	end

	logic signed [SW-1:0] m1e, m3e, offx, offy;

	always_comb begin
		m1e  = SW'(m1_s2);
		m3e  = SW'(m3_s2);
		offx = SW'(tx) <<< FRAC_BITS;
		offy = SW'(ty) <<< FRAC_BITS;
		if (mode_s2.inv) begin
			m1e = -m1e;
			m3e = -m3e;
		end
		if (!mode_s2.full) begin
			offx = '0;
			offy = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3 <= mode_s2;
			ex_s3   <= SW'(m0_s2) + m1e + offx;
			ey_s3   <= SW'(m2_s2) + m3e + offy;
			det_s3  <= (2*W+1)'(d0_s2) - (2*W+1)'(d1_s2);
		end
	end

endmodule

// ----- src/apt_div.sv -----
// Restoring divider pipeline, one quotient bit per stage.
// Stand-alone; no package use.
`timescale 1ns / 1ps

module apt_div #(
	parameter int DW = 66,
	parameter int QB = 33
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] den,
	input  logic [DW-1:0] rem_in,
	input  logic [QB-1:0] num_in,
	output logic [QB-1:0] quo
);

	logic [DW-1:0] rem_s [QB];
	logic [DW-1:0] den_s [QB];
	logic [QB-1:0] num_s [QB];
	logic [QB-1:0] quo_s [QB];

	logic [DW-1:0] rem_p [QB];
	logic [DW-1:0] den_p [QB];
	logic [QB-1:0] num_p [QB];
	logic [QB-1:0] quo_p [QB];

	assign rem_p[0] = rem_in;
	assign den_p[0] = den;
	assign num_p[0] = num_in;
	assign quo_p[0] = '0;

	for (genvar k = 1; k < QB; k++) begin : g_link
		assign rem_p[k] = rem_s[k-1];
		assign den_p[k] = den_s[k-1];
		assign num_p[k] = num_s[k-1];
		assign quo_p[k] = quo_s[k-1];
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DW:0] trial;
		logic        ge;
		assign trial = {rem_p[k], num_p[k][QB-1]};
		assign ge    = trial >= {1'b0, den_p[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(trial - {1'b0, den_p[k]}) : trial[DW-1:0];
				den_s[k] <= den_p[k];
				num_s[k] <= num_p[k] << 1;
				quo_s[k] <= {quo_p[k][QB-2:0], ge};
			end
		end
	end

	assign quo = quo_s[QB-1];

endmodule

// ----- src/affine_point_transform.sv -----
// Top level of the affine point transform: config registers, pipeline control,
// rounding, divider set-up and the output register. Uses apt_pkg, apt_mac, apt_div.
`timescale 1ns / 1ps

// Maps one signed fixed-point point per beat through the configured 2x3 affine
// matrix: full transform, linear part only, or inverse (adjugate over the
// determinant, rounded to nearest with ties away from zero). Fully pipelined:
// a new beat can be taken every clock while the pipe is not halted. Stages are
// operand prep, multiply, sum, sign/round, divider set-up, one stage per
// quotient bit of the two parallel restoring dividers, output register; the
// forward modes ride the same pipe so results leave in order. The whole pipe
// moves together and halts only while a finished beat sits unclaimed in the
// output register under out_stall. Config is written through cfg_we/cfg_idx/
// cfg_data and must only change while no beat is in flight.
module affine_point_transform #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  apt_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output apt_pkg::out_item_t            out_data,
	input  logic                          cfg_we,
	input  logic [apt_pkg::REG_IDX_W-1:0] cfg_idx,
	input  logic [apt_pkg::CW-1:0]        cfg_data
);

	localparam int W   = apt_pkg::CW;
	localparam int F   = FRAC_BITS;
	localparam int QB  = W + 1;          // quotient bits kept
	localparam int SW  = 2*W + 3;        // sum width
	localparam int DTW = 2*W + 1;        // determinant width
	localparam int DW  = 2*W + 2;        // divisor width (2*|det|)
	localparam int NW  = SW + F + 2;     // dividend width

	localparam logic [W-1:0]        ONE    = W'(1) << F;
	localparam logic [W-1:0]        MAXW   = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]        MINW   = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [SW-1:0] MAX_SW = SW'(MAXW);
	localparam logic signed [SW-1:0] MIN_SW = -(SW'(1) <<< (W-1));
	localparam logic [SW-1:0]       HALF   = SW'(1) << (F-1);
	localparam logic [QB-1:0]       TOP_P  = QB'(MAXW);
	localparam logic [QB-1:0]       TOP_N  = QB'(1) << (W-1);

	// beat state carried alongside the divider
	typedef struct packed {
		logic         inv;
		logic         sing;
		logic         neg_x;
		logic         neg_y;
		logic         big_x;
		logic         big_y;
		logic [W-1:0] fx;
		logic [W-1:0] fy;
		logic         fovf;
	} side_t;

	// ---------------------------------------------------------------------
	// Config registers
	// ---------------------------------------------------------------------
	logic signed [W-1:0] coef_q [apt_pkg::NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[apt_pkg::REG_SCALE_X]  <= ONE;
			coef_q[apt_pkg::REG_SHEAR_Y]  <= '0;
			coef_q[apt_pkg::REG_SHEAR_X]  <= '0;
			coef_q[apt_pkg::REG_SCALE_Y]  <= ONE;
			coef_q[apt_pkg::REG_OFFSET_X] <= '0;
			coef_q[apt_pkg::REG_OFFSET_Y] <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				apt_pkg::REG_SCALE_X:  coef_q[apt_pkg::REG_SCALE_X]  <= cfg_data;
				apt_pkg::REG_SHEAR_Y:  coef_q[apt_pkg::REG_SHEAR_Y]  <= cfg_data;
				apt_pkg::REG_SHEAR_X:  coef_q[apt_pkg::REG_SHEAR_X]  <= cfg_data;
				apt_pkg::REG_SCALE_Y:  coef_q[apt_pkg::REG_SCALE_Y]  <= cfg_data;
				apt_pkg::REG_OFFSET_X: coef_q[apt_pkg::REG_OFFSET_X] <= cfg_data;
				apt_pkg::REG_OFFSET_Y: coef_q[apt_pkg::REG_OFFSET_Y] <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Pipeline control: one enable for the whole pipe
	// ---------------------------------------------------------------------
	logic en;
	logic out_valid_q;
	apt_pkg::out_item_t out_data_q;

	assign en        = !(out_valid_q && out_stall);
	assign in_stall  = !en;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [QB-1:0] vd_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			vd_s        <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			vd_s        <= {vd_s[QB-2:0], v_s5};
			out_valid_q <= vd_s[QB-1];
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: decode request, remove translation for the inverse
	// ---------------------------------------------------------------------
	apt_pkg::mode_t          mode_s1, mode_in;
	logic signed [W:0]       ax_s1, by_s1;

	always_comb begin
		mode_in.inv  = in_data.req_type == apt_pkg::REQ_INVERSE;
		// unused code 3 behaves as the full transform
		mode_in.full = !mode_in.inv && in_data.req_type != apt_pkg::REQ_LINEAR;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode_in;
			if (mode_in.inv) begin
				ax_s1 <= (W+1)'(in_data.point_x) - (W+1)'(coef_q[apt_pkg::REG_OFFSET_X]);
				by_s1 <= (W+1)'(in_data.point_y) - (W+1)'(coef_q[apt_pkg::REG_OFFSET_Y]);
			end else begin
				ax_s1 <= (W+1)'(in_data.point_x);
				by_s1 <= (W+1)'(in_data.point_y);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stages 2-3: products and sums
	// ---------------------------------------------------------------------
	apt_pkg::mode_t          mode_s3;
	logic signed [SW-1:0]    ex_s3, ey_s3;
	logic signed [DTW-1:0]   det_s3;

	apt_mac #(.FRAC_BITS(F)) u_mac (
		.clk     (clk),
		.en      (en),
		.mode_s1 (mode_s1),
		.ax_s1   (ax_s1),
		.by_s1   (by_s1),
		.coef    (coef_q),
		.mode_s3 (mode_s3),
		.ex_s3   (ex_s3),
		.ey_s3   (ey_s3),
		.det_s3  (det_s3)
	);

	// ---------------------------------------------------------------------
	// Stage 4: forward rounding/saturation, magnitudes for the inverse
	// ---------------------------------------------------------------------
	// returns {overflow, value}; round half away from zero, then clamp
	function automatic logic [W:0] round_sat(input logic signed [SW-1:0] e);
		logic signed [SW-1:0] v;
		logic signed [SW-1:0] r;
		v = e + $signed(HALF) - $signed(SW'(e[SW-1]));
		r = v >>> F;
		if (r > MAX_SW)
			return {1'b1, MAXW};
		else if (r < MIN_SW)
			return {1'b1, MINW};
		else
			return {1'b0, r[W-1:0]};
	endfunction

	logic [W:0] rsx, rsy;
	assign rsx = round_sat(ex_s3);
	assign rsy = round_sat(ey_s3);

	side_t                s4_side, side_s4;
	logic [SW-1:0]        magx_s4, magy_s4;
	logic [DTW-1:0]       magd_s4;

	always_comb begin
		s4_side.inv   = mode_s3.inv;
		s4_side.sing  = mode_s3.inv && det_s3 == '0;
		s4_side.neg_x = ex_s3[SW-1] ^ det_s3[DTW-1];
		s4_side.neg_y = ey_s3[SW-1] ^ det_s3[DTW-1];
		s4_side.big_x = 1'b0;
		s4_side.big_y = 1'b0;
		s4_side.fx    = rsx[W-1:0];
		s4_side.fy    = rsy[W-1:0];
		s4_side.fovf  = rsx[W] | rsy[W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= s4_side;
			magx_s4 <= ex_s3[SW-1] ? SW'(-ex_s3) : SW'(ex_s3);
			magy_s4 <= ey_s3[SW-1] ? SW'(-ey_s3) : SW'(ey_s3);
			magd_s4 <= det_s3[DTW-1] ? DTW'(-det_s3) : DTW'(det_s3);
		end
	end

	// ---------------------------------------------------------------------
	// Stage 5: dividend (2|n|<<F + |d|), divisor 2|d|, early overflow
	// when the quotient would need more than QB bits
	// ---------------------------------------------------------------------
	logic [NW-1:0] nx, ny, hx, hy, dext;
	logic [DW-1:0] dd;
	side_t         s5_side, side_s5;
	logic [DW-1:0] den_s5, remx_s5, remy_s5;
	logic [QB-1:0] lox_s5, loy_s5;

	always_comb begin
		nx   = (NW'(magx_s4) << (F+1)) + NW'(magd_s4);
		ny   = (NW'(magy_s4) << (F+1)) + NW'(magd_s4);
		dd   = DW'(magd_s4) << 1;
		dext = NW'(dd);
		hx   = nx >> QB;
		hy   = ny >> QB;
		s5_side       = side_s4;
		s5_side.big_x = hx >= dext;
		s5_side.big_y = hy >= dext;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= s5_side;
			den_s5  <= dd;
			remx_s5 <= hx[DW-1:0];
			remy_s5 <= hy[DW-1:0];
			lox_s5  <= nx[QB-1:0];
			loy_s5  <= ny[QB-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// Divider stages, side data delayed to match
	// ---------------------------------------------------------------------
	logic [QB-1:0] qx, qy;

	apt_div #(.DW(DW), .QB(QB)) u_div_x (
		.clk    (clk),
		.en     (en),
		.den    (den_s5),
		.rem_in (remx_s5),
		.num_in (lox_s5),
		.quo    (qx)
	);

	apt_div #(.DW(DW), .QB(QB)) u_div_y (
		.clk    (clk),
		.en     (en),
		.den    (den_s5),
		.rem_in (remy_s5),
		.num_in (loy_s5),
		.quo    (qy)
	);

	side_t side_d_s [QB];

	always_ff @(posedge clk) begin
		if (en) begin
			side_d_s[0] <= side_s5;
			for (int k = 1; k < QB; k++) begin
				side_d_s[k] <= side_d_s[k-1];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Output: saturate the quotients, pick the result for the mode
	// ---------------------------------------------------------------------
	function automatic logic [W:0] quo_sat(input logic [QB-1:0] q, input logic neg,
			input logic big);
		logic [QB-1:0] top;
		logic [W-1:0]  mag;
		top = neg ? TOP_N : TOP_P;
		mag = q[W-1:0];
		if (big || q > top)
			return {1'b1, neg ? MINW : MAXW};
		else
			return {1'b0, neg ? W'(-mag) : mag};
	endfunction

	side_t              fin;
	logic [W:0]         dqx, dqy;
	apt_pkg::out_item_t res;

	always_comb begin
		fin = side_d_s[QB-1];
		dqx = quo_sat(qx, fin.neg_x, fin.big_x);
		dqy = quo_sat(qy, fin.neg_y, fin.big_y);
		if (fin.sing) begin
			res.result_x = '0;
			res.result_y = '0;
			res.overflow = 1'b0;
			res.singular = 1'b1;
		end else if (fin.inv) begin
			res.result_x = dqx[W-1:0];
			res.result_y = dqy[W-1:0];
			res.overflow = dqx[W] | dqy[W];
			res.singular = 1'b0;
		end else begin
			res.result_x = fin.fx;
			res.result_y = fin.fy;
			res.overflow = fin.fovf;
			res.singular = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= res;
		end
	end

endmodule

// ----- src/apt_chk.sv -----
// Port-level checker for the affine point transform, bound to the top level.
// Uses apt_pkg.
`timescale 1ns / 1ps

module apt_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input apt_pkg::out_item_t out_data
);

	localparam int W = apt_pkg::CW;
	localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output free");

	a_singular: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.singular |->
			out_data.result_x == '0 && out_data.result_y == '0 && !out_data.overflow)
		else $error("singular beat with non-zero result");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overflow |->
			out_data.result_x == MAXW || out_data.result_x == MINW ||
			out_data.result_y == MAXW || out_data.result_y == MINW)
		else $error("overflow without a saturated coordinate");

endmodule

bind affine_point_transform apt_chk u_apt_chk (.*);
